@@ src/ssf_pkg.sv @@
package ssf_pkg;

	localparam int WORD_W = 32;
	localparam int HS_W = 4;
	localparam int CFG_IDX_W = 3;

	// register reset values
	localparam logic PHYS_RST = 1'b0;
	localparam logic [15:0] SMOOTH_RST = 16'd43254;
	localparam logic [30:0] SPRING_RST = 31'd6553600;
	localparam logic [15:0] FRIC_RST = 16'd3277;
	localparam logic [30:0] REST_RST = 31'd655360;
	localparam logic signed [31:0] GRAV_X_RST = 32'sd0;
	localparam logic signed [31:0] GRAV_Y_RST = 32'sd65536000;
	localparam logic [30:0] MASS_RST = 31'd65536;

	// 1.0 in q16.16 and the rounding half
	localparam logic [16:0] ONE_Q16 = 17'h1_0000;
	localparam logic signed [65:0] HALF_Q16 = 66'sd32768;
	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHYSICS = 3'd0,
		CFG_SMOOTH  = 3'd1,
		CFG_SPRING  = 3'd2,
		CFG_FRIC    = 3'd3,
		CFG_REST    = 3'd4,
		CFG_GRAV_X  = 3'd5,
		CFG_GRAV_Y  = 3'd6,
		CFG_MASS    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0] time_step;
		logic restart;
		logic [HS_W-1:0] history_step;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sprite_x;
		logic signed [31:0] sprite_y;
		logic signed [31:0] sprite_vel_x;
		logic signed [31:0] sprite_vel_y;
		logic signed [31:0] smooth_x;
		logic signed [31:0] smooth_y;
		logic signed [31:0] past_x;
		logic signed [31:0] past_y;
		logic saturated;
	} out_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_ACCEPT, OP_LOAD,
		OP_SM_MUL, OP_SM_WR, OP_HV_DIV, OP_HV_WR, OP_ST_WR,
		OP_SQ_MUL, OP_SQ_WR, OP_RT, OP_RT_WR,
		OP_SH_MUL, OP_SH_DIV, OP_SH_WR,
		OP_AC_MUL, OP_AC_DIV, OP_AC_WR,
		OP_VA_MUL, OP_VA_WR, OP_VK_MUL, OP_VK_WR, OP_VP_MUL, OP_VP_WR,
		OP_COMMIT, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic cy;
	} cmd_t;

	typedef struct packed {
		logic start_track;
		logic physics;
		logic len_zero;
		logic div_done;
		logic sqrt_done;
	} status_t;

	// {clipped, value}
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > SAT_MAX) r = {1'b1, 32'h7FFF_FFFF};
		else if (v < SAT_MIN) r = {1'b1, 32'h8000_0000};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction

	// round to nearest, ties up, then drop 16 fraction bits
	function automatic logic signed [49:0] round16(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = v + HALF_Q16;
		return t[65:16];
	endfunction

endpackage

@@ src/spring_sprite_follower.sv @@
// channel  dir  handshake                    payload
// sample   in   sample_valid / sample_ready  ssf_pkg::in_t (one word per tracker sample)
// result   out  result_valid / result_ready  ssf_pkg::out_t (one word per sample)
// cfg      in   cfg_wr_en                    cfg_index, cfg_data (write only, no wait)
//
// timing: a track start skips the arithmetic; otherwise the 64-step shared divider
//   (hand velocity, rest length, spring force) dominates the time per word,
//   with the 32-step root unit added in spring mode
// one sample word is worked at a time; the next is taken once the current one is in
//   the result register, so it overlaps with a result word still waiting downstream
// reset: arst_n clears the controller, the track flag and the registers to their defaults
// stalls: a held result only stops the block when the next result is ready to go out
module spring_sprite_follower #(
	parameter int HISTORY_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input ssf_pkg::in_t sample,
	output logic result_valid,
	input logic result_ready,
	output ssf_pkg::out_t result,
	input logic cfg_wr_en,
	input logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ssf_pkg::WORD_W-1:0] cfg_data
);

	// controller to datapath: one micro-op and the coordinate it works on
	ssf_pkg::cmd_t cmd;
	// datapath to controller: track start, mode, zero length, unit done flags
	ssf_pkg::status_t status;

	// sequencer: one-hot state machine walking x then y through each phase
	ssf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.cmd(cmd)
	);

	// datapath: config registers, histories, shared multiplier, divider and root unit,
	// saturation and the result register
	ssf_dpath #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.sample(sample),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result(result)
	);

endmodule

@@ src/ssf_div.sv @@
module ssf_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [63:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic signed [63:0] quotient
);

	localparam int DW = 64;
	localparam int CW = $clog2(DW);

	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic fits;
	logic [DW-1:0] mag;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff = trial - {1'b0, den_q};
		fits = trial >= {1'b0, den_q};
		mag = dividend[DW-1] ? (~dividend + 64'd1) : dividend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(DW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

@@ src/ssf_sqrt.sv @@
module ssf_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] radicand,
	output logic done,
	output logic [31:0] root
);

	localparam int STEPS = 32;
	localparam int CW = $clog2(STEPS);

	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] trial;
	logic ge;

	always_comb begin
		trial = r_q + bit_q;
		ge = v_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (ge) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign root = r_q[31:0];

endmodule

@@ src/ssf_dpath.sv @@
module ssf_dpath #(
	parameter int HISTORY_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input ssf_pkg::cmd_t cmd,
	output ssf_pkg::status_t status,
	input ssf_pkg::in_t sample,
	input logic cfg_wr_en,
	input logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ssf_pkg::WORD_W-1:0] cfg_data,
	output ssf_pkg::out_t result
);

	// entries older than the widest history_step can never be reported
	localparam int HS_SPAN = 2 ** ssf_pkg::HS_W;
	localparam int NH = (HISTORY_DEPTH < HS_SPAN) ? HISTORY_DEPTH : HS_SPAN;
	localparam int HIW = $clog2(NH);

	logic phys_q;
	logic [15:0] smc_q;
	logic [30:0] spring_q;
	logic [15:0] fric_q;
	logic [30:0] rest_q;
	logic signed [31:0] grav_q [2];
	logic [30:0] mass_q;

	logic signed [31:0] pos_q [2];
	logic [15:0] dt_q;
	logic rst_q;
	logic [HIW-1:0] hs_q;
	logic started_q;
	logic signed [31:0] hand_q [2];
	logic signed [31:0] hist_q [NH][2];
	logic signed [31:0] vel_q [2];
	logic signed [31:0] sm_q [2];
	logic signed [31:0] hv_q [2];
	logic signed [31:0] st_q [2];
	logic signed [31:0] acc_q [2];
	logic signed [31:0] np_q [2];
	logic [63:0] sumsq_q;
	logic [31:0] len_q;
	logic signed [65:0] prod_q;
	logic sat_q;
	ssf_pkg::out_t out_q;

	logic c;
	logic [16:0] keep;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic signed [49:0] rnd;
	logic signed [65:0] wsum;
	logic [32:0] wres;
	logic wr_flag;
	logic signed [32:0] hv_diff;
	logic div_start;
	logic signed [63:0] div_num;
	logic [31:0] div_den;
	logic div_done;
	logic signed [63:0] quot;
	logic rt_start;
	logic rt_done;
	logic [31:0] root;

	assign c = cmd.cy;

	always_comb begin
		keep = ssf_pkg::ONE_Q16 - {1'b0, fric_q};
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			ssf_pkg::OP_SM_MUL: begin
				mul_a = {hand_q[c][31], hand_q[c]} - {pos_q[c][31], pos_q[c]};
				mul_b = {17'b0, smc_q};
			end
			ssf_pkg::OP_SQ_MUL: begin
				mul_a = {st_q[c][31], st_q[c]};
				mul_b = {st_q[c][31], st_q[c]};
			end
			ssf_pkg::OP_SH_MUL: begin
				mul_a = {st_q[c][31], st_q[c]};
				mul_b = {2'b0, rest_q};
			end
			ssf_pkg::OP_AC_MUL: begin
				mul_a = {st_q[c][31], st_q[c]};
				mul_b = {2'b0, spring_q};
			end
			ssf_pkg::OP_VA_MUL: begin
				mul_a = {acc_q[c][31], acc_q[c]};
				mul_b = {17'b0, dt_q};
			end
			ssf_pkg::OP_VK_MUL: begin
				mul_a = {vel_q[c][31], vel_q[c]};
				mul_b = {16'b0, keep};
			end
			ssf_pkg::OP_VP_MUL: begin
				mul_a = {vel_q[c][31], vel_q[c]};
				mul_b = {17'b0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 66'(mul_a) * 66'(mul_b);
	assign rnd = ssf_pkg::round16(prod_q);

	always_comb begin
		wsum = '0;
		wr_flag = 1'b0;
		case (cmd.op)
			ssf_pkg::OP_SM_WR: begin
				wsum = 66'(pos_q[c]) + 66'(rnd);
				wr_flag = 1'b1;
			end
			ssf_pkg::OP_HV_WR: begin
				wsum = 66'(quot);
				wr_flag = 1'b1;
			end
			ssf_pkg::OP_ST_WR: begin
				wsum = 66'(hist_q[0][c]) - 66'(sm_q[c]);
				wr_flag = 1'b1;
			end
			ssf_pkg::OP_SH_WR: begin
				wsum = 66'(st_q[c]) - 66'(quot);
				wr_flag = 1'b1;
			end
			ssf_pkg::OP_AC_WR: begin
				wsum = 66'(grav_q[c]) - 66'(quot);
				wr_flag = 1'b1;
			end
			ssf_pkg::OP_VA_WR: begin
				wsum = 66'(vel_q[c]) + 66'(rnd);
				wr_flag = 1'b1;
			end
			ssf_pkg::OP_VK_WR: begin
				wsum = 66'(rnd);
				wr_flag = 1'b1;
			end
			ssf_pkg::OP_VP_WR: begin
				wsum = 66'(hist_q[0][c]) + 66'(rnd);
				wr_flag = 1'b1;
			end
			default: begin
				wsum = '0;
				wr_flag = 1'b0;
			end
		endcase
		wres = ssf_pkg::sat32(wsum);
	end

	// divider operands: hand velocity, rest length shortening, spring accel
	always_comb begin
		hv_diff = {sm_q[c][31], sm_q[c]} - {hand_q[c][31], hand_q[c]};
		div_start = 1'b0;
		div_num = prod_q[63:0];
		div_den = {1'b0, mass_q};
		case (cmd.op)
			ssf_pkg::OP_HV_DIV: begin
				div_start = 1'b1;
				div_num = {{15{hv_diff[32]}}, hv_diff, 16'b0};
				div_den = {16'b0, dt_q};
			end
			ssf_pkg::OP_SH_DIV: begin
				div_start = 1'b1;
				div_den = len_q;
			end
			ssf_pkg::OP_AC_DIV: begin
				div_start = 1'b1;
				div_den = (mass_q == '0) ? 32'd1 : {1'b0, mass_q};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign rt_start = (cmd.op == ssf_pkg::OP_RT);

	ssf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_num),
		.divisor(div_den),
		.done(div_done),
		.quotient(quot)
	);

	ssf_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(rt_start),
		.radicand(sumsq_q),
		.done(rt_done),
		.root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			phys_q <= ssf_pkg::PHYS_RST;
			smc_q <= ssf_pkg::SMOOTH_RST;
			spring_q <= ssf_pkg::SPRING_RST;
			fric_q <= ssf_pkg::FRIC_RST;
			rest_q <= ssf_pkg::REST_RST;
			grav_q[0] <= ssf_pkg::GRAV_X_RST;
			grav_q[1] <= ssf_pkg::GRAV_Y_RST;
			mass_q <= ssf_pkg::MASS_RST;
		end else begin
			if (cmd.op == ssf_pkg::OP_LOAD) started_q <= 1'b1;
			if (cfg_wr_en) begin
				case (ssf_pkg::cfg_idx_t'(cfg_index))
					ssf_pkg::CFG_PHYSICS: phys_q <= cfg_data[0];
					ssf_pkg::CFG_SMOOTH: smc_q <= cfg_data[15:0];
					ssf_pkg::CFG_SPRING: spring_q <= cfg_data[30:0];
					ssf_pkg::CFG_FRIC: fric_q <= cfg_data[15:0];
					ssf_pkg::CFG_REST: rest_q <= cfg_data[30:0];
					ssf_pkg::CFG_GRAV_X: grav_q[0] <= cfg_data;
					ssf_pkg::CFG_GRAV_Y: grav_q[1] <= cfg_data;
					ssf_pkg::CFG_MASS: mass_q <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ssf_pkg::OP_ACCEPT: begin
				pos_q[0] <= sample.pos_x;
				pos_q[1] <= sample.pos_y;
				dt_q <= (sample.time_step == '0) ? 16'd1 : sample.time_step;
				rst_q <= sample.restart;
				if ({28'b0, sample.history_step} > 32'(NH - 1)) hs_q <= HIW'(NH - 1);
				else hs_q <= HIW'(sample.history_step);
				sat_q <= 1'b0;
			end
			ssf_pkg::OP_LOAD: begin
				for (int i = 0; i < NH; i++) begin
					hist_q[i][0] <= pos_q[0];
					hist_q[i][1] <= pos_q[1];
				end
				hand_q[0] <= pos_q[0];
				hand_q[1] <= pos_q[1];
				vel_q[0] <= '0;
				vel_q[1] <= '0;
			end
			ssf_pkg::OP_SM_MUL, ssf_pkg::OP_SQ_MUL, ssf_pkg::OP_SH_MUL,
			ssf_pkg::OP_AC_MUL, ssf_pkg::OP_VA_MUL, ssf_pkg::OP_VK_MUL,
			ssf_pkg::OP_VP_MUL: prod_q <= mul_p;
			ssf_pkg::OP_SM_WR: sm_q[c] <= wres[31:0];
			ssf_pkg::OP_HV_WR: hv_q[c] <= wres[31:0];
			ssf_pkg::OP_ST_WR, ssf_pkg::OP_SH_WR: st_q[c] <= wres[31:0];
			ssf_pkg::OP_AC_WR: acc_q[c] <= wres[31:0];
			ssf_pkg::OP_VA_WR, ssf_pkg::OP_VK_WR: vel_q[c] <= wres[31:0];
			ssf_pkg::OP_VP_WR: np_q[c] <= wres[31:0];
			ssf_pkg::OP_SQ_WR: sumsq_q <= c ? (sumsq_q + prod_q[63:0]) : prod_q[63:0];
			ssf_pkg::OP_RT_WR: len_q <= root;
			ssf_pkg::OP_COMMIT: begin
				hand_q[0] <= sm_q[0];
				hand_q[1] <= sm_q[1];
				for (int i = NH - 1; i > 0; i--) begin
					hist_q[i][0] <= hist_q[i-1][0];
					hist_q[i][1] <= hist_q[i-1][1];
				end
				hist_q[0][0] <= phys_q ? np_q[0] : sm_q[0];
				hist_q[0][1] <= phys_q ? np_q[1] : sm_q[1];
				if (!phys_q) begin
					vel_q[0] <= hv_q[0];
					vel_q[1] <= hv_q[1];
				end
			end
			ssf_pkg::OP_OUT: begin
				out_q.sprite_x <= hist_q[0][0];
				out_q.sprite_y <= hist_q[0][1];
				out_q.sprite_vel_x <= vel_q[0];
				out_q.sprite_vel_y <= vel_q[1];
				out_q.smooth_x <= hand_q[0];
				out_q.smooth_y <= hand_q[1];
				out_q.past_x <= hist_q[hs_q][0];
				out_q.past_y <= hist_q[hs_q][1];
				out_q.saturated <= sat_q;
			end
			default: ;
		endcase
		if (wr_flag && wres[32]) sat_q <= 1'b1;
	end

	assign status = '{
		start_track: rst_q | ~started_q,
		physics: phys_q,
		len_zero: (len_q == '0),
		div_done: div_done,
		sqrt_done: rt_done
	};
	assign result = out_q;

endmodule

@@ src/ssf_ctrl.sv @@
module ssf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	output logic result_valid,
	input logic result_ready,
	input ssf_pkg::status_t status,
	output ssf_pkg::cmd_t cmd
);

	typedef enum logic [29:0] {
		ST_IDLE    = 30'h0000_0001,
		ST_CHECK   = 30'h0000_0002,
		ST_LOAD    = 30'h0000_0004,
		ST_SM_MUL  = 30'h0000_0008,
		ST_SM_WR   = 30'h0000_0010,
		ST_HV_DIV  = 30'h0000_0020,
		ST_HV_WAIT = 30'h0000_0040,
		ST_HV_WR   = 30'h0000_0080,
		ST_ST_WR   = 30'h0000_0100,
		ST_SQ_MUL  = 30'h0000_0200,
		ST_SQ_WR   = 30'h0000_0400,
		ST_RT_GO   = 30'h0000_0800,
		ST_RT_WAIT = 30'h0000_1000,
		ST_RT_WR   = 30'h0000_2000,
		ST_SH_MUL  = 30'h0000_4000,
		ST_SH_DIV  = 30'h0000_8000,
		ST_SH_WAIT = 30'h0001_0000,
		ST_SH_WR   = 30'h0002_0000,
		ST_AC_MUL  = 30'h0004_0000,
		ST_AC_DIV  = 30'h0008_0000,
		ST_AC_WAIT = 30'h0010_0000,
		ST_AC_WR   = 30'h0020_0000,
		ST_VA_MUL  = 30'h0040_0000,
		ST_VA_WR   = 30'h0080_0000,
		ST_VK_MUL  = 30'h0100_0000,
		ST_VK_WR   = 30'h0200_0000,
		ST_VP_MUL  = 30'h0400_0000,
		ST_VP_WR   = 30'h0800_0000,
		ST_COMMIT  = 30'h1000_0000,
		ST_FIN     = 30'h2000_0000
	} state_t;

	state_t state_q, state_d;
	logic cy_q, cy_d;
	logic out_valid_q;
	logic can_load;

	assign can_load = !out_valid_q || result_ready;
	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cy_d = cy_q;
		cmd.cy = cy_q;
		cmd.op = ssf_pkg::OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.op = ssf_pkg::OP_ACCEPT;
					cy_d = 1'b0;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = status.start_track ? ST_LOAD : ST_SM_MUL;
			ST_LOAD: begin
				cmd.op = ssf_pkg::OP_LOAD;
				state_d = ST_FIN;
			end
			ST_SM_MUL: begin
				cmd.op = ssf_pkg::OP_SM_MUL;
				state_d = ST_SM_WR;
			end
			ST_SM_WR: begin
				cmd.op = ssf_pkg::OP_SM_WR;
				state_d = ST_HV_DIV;
			end
			ST_HV_DIV: begin
				cmd.op = ssf_pkg::OP_HV_DIV;
				state_d = ST_HV_WAIT;
			end
			ST_HV_WAIT: if (status.div_done) state_d = ST_HV_WR;
			ST_HV_WR, ST_ST_WR: begin
				cmd.op = (state_q == ST_HV_WR) ? ssf_pkg::OP_HV_WR : ssf_pkg::OP_ST_WR;
				if (state_q == ST_HV_WR && status.physics) begin
					state_d = ST_ST_WR;
				end else if (!cy_q) begin
					cy_d = 1'b1;
					state_d = ST_SM_MUL;
				end else begin
					cy_d = 1'b0;
					state_d = status.physics ? ST_SQ_MUL : ST_COMMIT;
				end
			end
			ST_SQ_MUL: begin
				cmd.op = ssf_pkg::OP_SQ_MUL;
				state_d = ST_SQ_WR;
			end
			ST_SQ_WR: begin
				cmd.op = ssf_pkg::OP_SQ_WR;
				cy_d = ~cy_q;
				state_d = cy_q ? ST_RT_GO : ST_SQ_MUL;
			end
			ST_RT_GO: begin
				cmd.op = ssf_pkg::OP_RT;
				state_d = ST_RT_WAIT;
			end
			ST_RT_WAIT: if (status.sqrt_done) state_d = ST_RT_WR;
			ST_RT_WR: begin
				cmd.op = ssf_pkg::OP_RT_WR;
				state_d = ST_SH_MUL;
			end
			ST_SH_MUL: begin
				cmd.op = ssf_pkg::OP_SH_MUL;
				state_d = status.len_zero ? ST_AC_MUL : ST_SH_DIV;
			end
			ST_SH_DIV: begin
				cmd.op = ssf_pkg::OP_SH_DIV;
				state_d = ST_SH_WAIT;
			end
			ST_SH_WAIT: if (status.div_done) state_d = ST_SH_WR;
			ST_SH_WR: begin
				cmd.op = ssf_pkg::OP_SH_WR;
				state_d = ST_AC_MUL;
			end
			ST_AC_MUL: begin
				cmd.op = ssf_pkg::OP_AC_MUL;
				state_d = ST_AC_DIV;
			end
			ST_AC_DIV: begin
				cmd.op = ssf_pkg::OP_AC_DIV;
				state_d = ST_AC_WAIT;
			end
			ST_AC_WAIT: if (status.div_done) state_d = ST_AC_WR;
			ST_AC_WR: begin
				cmd.op = ssf_pkg::OP_AC_WR;
				state_d = ST_VA_MUL;
			end
			ST_VA_MUL: begin
				cmd.op = ssf_pkg::OP_VA_MUL;
				state_d = ST_VA_WR;
			end
			ST_VA_WR: begin
				cmd.op = ssf_pkg::OP_VA_WR;
				state_d = ST_VK_MUL;
			end
			ST_VK_MUL: begin
				cmd.op = ssf_pkg::OP_VK_MUL;
				state_d = ST_VK_WR;
			end
			ST_VK_WR: begin
				cmd.op = ssf_pkg::OP_VK_WR;
				state_d = ST_VP_MUL;
			end
			ST_VP_MUL: begin
				cmd.op = ssf_pkg::OP_VP_MUL;
				state_d = ST_VP_WR;
			end
			ST_VP_WR: begin
				cmd.op = ssf_pkg::OP_VP_WR;
				cy_d = ~cy_q;
				state_d = cy_q ? ST_COMMIT : ST_SH_MUL;
			end
			ST_COMMIT: begin
				cmd.op = ssf_pkg::OP_COMMIT;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (can_load) begin
					cmd.op = ssf_pkg::OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cy_q <= cy_d;
			if (state_q == ST_FIN && can_load) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == ST_HV_WAIT || state_q == ST_SH_WAIT ||
			state_q == ST_AC_WAIT))
		else $error("divider finished outside a wait state");

	a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.sqrt_done |-> (state_q == ST_RT_WAIT))
		else $error("root unit finished outside its wait state");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised without leaving the finish state");

	a_check_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> $past(state_q == ST_IDLE && sample_valid))
		else $error("track check entered without an accepted word");

endmodule

@@ dv/spring_sprite_follower_tb.sv @@
module spring_sprite_follower_tb;

	localparam int DEPTH = 16;
	localparam int LONG_HOLD = 2000;
	// slowest word is a spring-mode word, and the tail wait covers one such word
	localparam int TAIL_CYCLES = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	ssf_pkg::in_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	ssf_pkg::out_t result;
	logic cfg_wr_en = 1'b0;
	logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ssf_pkg::WORD_W-1:0] cfg_data = '0;

	always #4 clk = ~clk;

	spring_sprite_follower #(.HISTORY_DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ---------------------------------------------------------------
	// follower prediction: own copy of histories, velocity and registers
	// ---------------------------------------------------------------
	longint hand_x[DEPTH], hand_y[DEPTH];
	longint spr_x[DEPTH], spr_y[DEPTH];
	longint vel_x, vel_y;
	bit track_live;
	bit clip_seen;

	bit m_physics;
	longint m_smooth, m_spring, m_fric, m_rest, m_grav_x, m_grav_y, m_mass;

	ssf_pkg::out_t follow_q[$];   // words still owed by the block
	int fail_count = 0;
	bit idle_on = 1'b1;
	bit long_req = 1'b0;

	function void reset_follower();
		for (int i = 0; i < DEPTH; i++) begin
			hand_x[i] = 0; hand_y[i] = 0; spr_x[i] = 0; spr_y[i] = 0;
		end
		vel_x = 0; vel_y = 0;
		track_live = 0;
		m_physics = 0;
		m_smooth = 43254;
		m_spring = 6553600;
		m_fric = 3277;
		m_rest = 655360;
		m_grav_x = 0;
		m_grav_y = 65536000;
		m_mass = 65536;
	endfunction

	// clip to 32-bit signed and note it
	function longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			clip_seen = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clip_seen = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// round to nearest, ties up, drop 16 fraction bits
	function longint rnd16(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function longint unsigned floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function ssf_pkg::out_t follow_step(ssf_pkg::in_t it);
		longint px, py, dt, sx, sy, phx, phy, hvx, hvy;
		longint qx, qy, stx, sty, nx, ny, ax, ay, keep, m;
		longint unsigned len;
		int hs;
		ssf_pkg::out_t o;
		px = longint'(it.pos_x);
		py = longint'(it.pos_y);
		dt = (it.time_step == 0) ? 1 : longint'(it.time_step);
		hs = it.history_step;
		clip_seen = 0;
		if (it.restart || !track_live) begin
			// new track: both histories take the raw position
			for (int i = 0; i < DEPTH; i++) begin
				hand_x[i] = px; hand_y[i] = py; spr_x[i] = px; spr_y[i] = py;
			end
			vel_x = 0; vel_y = 0;
			track_live = 1;
		end else begin
			phx = hand_x[0];
			phy = hand_y[0];
			sx = clip32(rnd16(px * (65536 - m_smooth) + phx * m_smooth));
			sy = clip32(rnd16(py * (65536 - m_smooth) + phy * m_smooth));
			for (int i = DEPTH - 1; i > 0; i--) begin
				hand_x[i] = hand_x[i-1]; hand_y[i] = hand_y[i-1];
			end
			hand_x[0] = sx; hand_y[0] = sy;
			hvx = clip32(((sx - phx) * 65536) / dt);
			hvy = clip32(((sy - phy) * 65536) / dt);
			if (m_physics) begin
				qx = spr_x[0];
				qy = spr_y[0];
				m = (m_mass == 0) ? 1 : m_mass;
				keep = 65536 - m_fric;
				stx = clip32(qx - sx);
				sty = clip32(qy - sy);
				len = floor_root(longint'(stx * stx) + longint'(sty * sty));
				// zero length leaves the stretch as it is
				if (len != 0) begin
					stx = clip32(stx - (m_rest * stx) / longint'(len));
					sty = clip32(sty - (m_rest * sty) / longint'(len));
				end
				ax = clip32(-((stx * m_spring) / m) + m_grav_x);
				ay = clip32(-((sty * m_spring) / m) + m_grav_y);
				vel_x = clip32(vel_x + rnd16(ax * dt));
				vel_y = clip32(vel_y + rnd16(ay * dt));
				vel_x = clip32(rnd16(vel_x * keep));
				vel_y = clip32(rnd16(vel_y * keep));
				nx = clip32(qx + rnd16(vel_x * dt));
				ny = clip32(qy + rnd16(vel_y * dt));
			end else begin
				nx = sx; ny = sy;
				vel_x = hvx; vel_y = hvy;
			end
			for (int i = DEPTH - 1; i > 0; i--) begin
				spr_x[i] = spr_x[i-1]; spr_y[i] = spr_y[i-1];
			end
			spr_x[0] = nx; spr_y[0] = ny;
		end
		o.sprite_x = spr_x[0][31:0];
		o.sprite_y = spr_y[0][31:0];
		o.sprite_vel_x = vel_x[31:0];
		o.sprite_vel_y = vel_y[31:0];
		o.smooth_x = hand_x[0][31:0];
		o.smooth_y = hand_y[0][31:0];
		o.past_x = spr_x[hs][31:0];
		o.past_y = spr_y[hs][31:0];
		o.saturated = clip_seen;
		return o;
	endfunction

	// ---------------------------------------------------------------
	// result side: checks every accepted word, drives ready with stalls
	// ---------------------------------------------------------------
	int stall_left = 0;
	int hold_left = 0;

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		ssf_pkg::out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (follow_q.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				want = follow_q.pop_front();
				check_field("sprite_x", want.sprite_x, result.sprite_x);
				check_field("sprite_y", want.sprite_y, result.sprite_y);
				check_field("sprite_vel_x", want.sprite_vel_x, result.sprite_vel_x);
				check_field("sprite_vel_y", want.sprite_vel_y, result.sprite_vel_y);
				check_field("smooth_x", want.smooth_x, result.smooth_x);
				check_field("smooth_y", want.smooth_y, result.smooth_y);
				check_field("past_x", want.past_x, result.past_x);
				check_field("past_y", want.past_y, result.past_y);
				check_field("saturated", 32'(want.saturated), 32'(result.saturated));
			end
		end
		// long hold-off counted here so the sender keeps pushing meanwhile
		if (long_req && hold_left == 0) hold_left = LONG_HOLD;
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left--;
			if (hold_left == 0) long_req = 0;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// sample side
	// ---------------------------------------------------------------

	// offer one word, optionally after an idle burst; valid stays up afterward
	task automatic send_sample(ssf_pkg::in_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= it;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		follow_q.insert(follow_q.size(), follow_step(it));
	endtask

	// stop offering and let every owed word come back, then settle
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (follow_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(ssf_pkg::cfg_idx_t idx, logic [31:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			ssf_pkg::CFG_PHYSICS: m_physics = d[0];
			ssf_pkg::CFG_SMOOTH: m_smooth = longint'(d[15:0]);
			ssf_pkg::CFG_SPRING: m_spring = longint'(d[30:0]);
			ssf_pkg::CFG_FRIC: m_fric = longint'(d[15:0]);
			ssf_pkg::CFG_REST: m_rest = longint'(d[30:0]);
			ssf_pkg::CFG_GRAV_X: m_grav_x = longint'(signed'(d));
			ssf_pkg::CFG_GRAV_Y: m_grav_y = longint'(signed'(d));
			ssf_pkg::CFG_MASS: m_mass = longint'(d[30:0]);
			default: ;
		endcase
	endtask

	function ssf_pkg::in_t make_word(logic [31:0] x, logic [31:0] y, logic [15:0] dt,
			logic rs, logic [3:0] hs);
		ssf_pkg::in_t it;
		it.pos_x = x;
		it.pos_y = y;
		it.time_step = dt;
		it.restart = rs;
		it.history_step = hs;
		return it;
	endfunction

	// mostly a wandering hand with small steps; some wild words and restarts
	function ssf_pkg::in_t rand_word();
		ssf_pkg::in_t it;
		int mode;
		mode = $urandom_range(0, 9);
		it.pos_x = (mode == 0) ? $urandom()
			: $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
		it.pos_y = (mode == 0) ? $urandom()
			: $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
		it.time_step = (mode == 1) ? 16'($urandom()) : 16'($urandom_range(1, 4000));
		it.restart = ($urandom_range(0, 24) == 0);
		it.history_step = 4'($urandom());
		return it;
	endfunction

	task automatic send_random(int n);
		for (int i = 0; i < n; i++) send_sample(rand_word());
	endtask

	// random register setting, extremes now and then
	task automatic random_regs(bit phys);
		write_reg(ssf_pkg::CFG_PHYSICS, 32'(phys));
		write_reg(ssf_pkg::CFG_SMOOTH,
			($urandom_range(0, 5) == 0) ? 32'hFFFF : $urandom_range(0, 65535));
		write_reg(ssf_pkg::CFG_SPRING,
			($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 32'h0100_0000));
		write_reg(ssf_pkg::CFG_FRIC, $urandom_range(0, 65535));
		write_reg(ssf_pkg::CFG_REST,
			($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 32'h0100_0000));
		write_reg(ssf_pkg::CFG_GRAV_X, ($urandom_range(0, 5) == 0) ? $urandom()
			: $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
		write_reg(ssf_pkg::CFG_GRAV_Y, ($urandom_range(0, 5) == 0) ? $urandom()
			: $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
		write_reg(ssf_pkg::CFG_MASS,
			($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 32'h0100_0000));
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// copy mode with reset registers: first word starts a track, then field extremes
	task automatic test_copy_directed();
		send_sample(make_word(32'h7FFF_FFFF, 32'h8000_0000, 16'd1, 1'b0, 4'd0));
		send_sample(make_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd1, 1'b0, 4'd15));
		send_sample(make_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1'b0, 4'd3));   // zero step
		send_sample(make_word(32'h0, 32'h0, 16'hFFFF, 1'b0, 4'd15));
		send_sample(make_word(32'h0001_0000, 32'hFFFF_0000, 16'd0, 1'b1, 4'd1));  // restart
		send_sample(make_word(32'h0100_0000, 32'hFF00_0000, 16'd655, 1'b0, 4'd2));
		send_sample(make_word(32'hFFFF_FFFF, 32'h0000_0001, 16'h8000, 1'b0, 4'd15));
		drain();
		// smoothing extremes: none and full hold
		write_reg(ssf_pkg::CFG_SMOOTH, 32'd0);
		send_sample(make_word(32'h7FFF_FFFF, 32'h8000_0000, 16'd1, 1'b0, 4'd4));
		send_sample(make_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd1, 1'b0, 4'd1));
		drain();
		write_reg(ssf_pkg::CFG_SMOOTH, 32'hFFFF);
		send_sample(make_word(32'h1234_5678, 32'h8765_4321, 16'd7, 1'b0, 4'd0));
		drain();
	endtask

	// spring mode: default registers, then extreme settings
	task automatic test_spring_directed();
		write_reg(ssf_pkg::CFG_PHYSICS, 32'd1);
		write_reg(ssf_pkg::CFG_SMOOTH, 32'd43254);
		send_sample(make_word(32'h0064_0000, 32'h0032_0000, 16'd1092, 1'b1, 4'd0));
		send_sample(make_word(32'h0064_0000, 32'h0032_0000, 16'd1092, 1'b0, 4'd0));  // zero stretch
		send_sample(make_word(32'h00C8_0000, 32'h0000_0000, 16'd1092, 1'b0, 4'd1));
		send_sample(make_word(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0, 4'd15));
		drain();
		write_reg(ssf_pkg::CFG_SPRING, 32'h7FFF_FFFF);
		write_reg(ssf_pkg::CFG_FRIC, 32'hFFFF);
		write_reg(ssf_pkg::CFG_REST, 32'h7FFF_FFFF);
		write_reg(ssf_pkg::CFG_GRAV_X, 32'h8000_0000);
		write_reg(ssf_pkg::CFG_GRAV_Y, 32'h7FFF_FFFF);
		write_reg(ssf_pkg::CFG_MASS, 32'd0);  // zero mass acts as smallest
		send_sample(make_word(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1'b0, 4'd2));
		send_sample(make_word(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0, 4'd15));
		drain();
		write_reg(ssf_pkg::CFG_SPRING, 32'd0);
		write_reg(ssf_pkg::CFG_FRIC, 32'd0);
		write_reg(ssf_pkg::CFG_REST, 32'd0);
		write_reg(ssf_pkg::CFG_GRAV_X, 32'h7FFF_FFFF);
		write_reg(ssf_pkg::CFG_GRAV_Y, 32'h8000_0000);
		write_reg(ssf_pkg::CFG_MASS, 32'h7FFF_FFFF);
		send_sample(make_word(32'h0, 32'h0, 16'hFFFF, 1'b1, 4'd0));
		send_sample(make_word(32'h0001_0000, 32'h0001_0000, 16'hFFFF, 1'b0, 4'd1));
		send_sample(make_word(32'h0002_0000, 32'h0, 16'hFFFF, 1'b0, 4'd15));
		drain();
	endtask

	// receiver holds off long while words keep coming, then the sender waits out the queue
	task automatic test_backpressure();
		random_regs(1'b0);
		long_req = 1;
		send_random(12);
		drain();
	endtask

	// random phases alternating copy and spring mode
	task automatic test_random_phases();
		for (int ph = 0; ph < 10; ph++) begin
			random_regs(ph[0]);
			send_random((ph[0]) ? 45 : 70);
			drain();
		end
	endtask

	// closing stretch without any idling on either side
	task automatic test_no_idle();
		idle_on = 0;
		random_regs(1'b1);
		send_random(30);
		drain();
		write_reg(ssf_pkg::CFG_PHYSICS, 32'd0);
		send_random(30);
	endtask

	initial begin
		reset_follower();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_copy_directed();
		test_spring_directed();
		test_backpressure();
		test_random_phases();
		test_no_idle();
		// wait for the last words, then a tail to catch strays
		sample_valid <= 1'b0;
		@(posedge clk);
		while (follow_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#40000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
src/ssf_pkg.sv
src/ssf_div.sv
src/ssf_sqrt.sv
src/ssf_dpath.sv
src/ssf_ctrl.sv
src/spring_sprite_follower.sv
dv/spring_sprite_follower_tb.sv
